// File: hw/rtl/rci_pkg.sv
// Shared types and constants of the ray / double cone intersection block.
package rci_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_Y_LOWER     = 2'd0;
  localparam logic [1:0] CFG_Y_UPPER     = 2'd1;
  localparam logic [1:0] CFG_CAPS_CLOSED = 2'd2;
  localparam logic [1:0] CFG_NEAR_ZERO   = 2'd3;

  // Reset values of the configuration registers
  localparam logic signed [15:0] Y_LOWER_RST   = -16'sd1;
  localparam logic signed [15:0] Y_UPPER_RST   = 16'sd0;
  localparam logic               CAPS_RST      = 1'b0;
  localparam logic [15:0]        NEAR_ZERO_RST = 16'd7;

  // Result kinds
  localparam logic [1:0] KIND_SIDE_NEAR = 2'd0;
  localparam logic [1:0] KIND_SIDE_FAR  = 2'd1;
  localparam logic [1:0] KIND_LOWER_CAP = 2'd2;
  localparam logic [1:0] KIND_UPPER_CAP = 2'd3;

  // Divider operand widths
  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 34;

  typedef struct packed {
    logic signed [15:0] y_lower;
    logic signed [15:0] y_upper;
    logic               caps_closed;
    logic        [15:0] near_zero;
  } rci_cfg_t;

  typedef struct packed {
    logic a_tiny;
    logic b_tiny;
    logic dy_tiny;
    logic disc_neg;
  } rci_class_t;

  // One classified ray as handed from the front end to the back end
  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [63:0] disc;
    rci_class_t         cls;
  } rci_ray_t;

endpackage

// File: hw/rtl/rci_front.sv
// Front end: takes a ray, forms the quadratic coefficients and discriminant, classifies.
module rci_front import rci_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  rci_cfg_t           cfg,
  input  logic               q_full,
  output logic               q_push,
  output rci_ray_t           q_data
);

  localparam logic signed [50:0] COEF_MAX = 51'sd1073741823;

  typedef enum logic [2:0] {F_IDLE, F_MAC, F_CLAMP, F_DISC, F_PUSH} state_t;

  state_t             state_r;
  logic        [3:0]  step_r;
  rci_ray_t           ray_r;
  logic signed [63:0] prod_r;
  logic signed [49:0] a_acc_r, b_acc_r, c_acc_r;
  logic signed [63:0] bb_r;
  logic signed [31:0] mul_a, mul_b;
  logic signed [49:0] fl_prod;
  logic signed [63:0] disc_nxt;

  function automatic logic signed [31:0] clamp_coef(input logic signed [50:0] v);
    if (v > COEF_MAX) begin
      return 32'(COEF_MAX);
    end else if (v < -COEF_MAX) begin
      return 32'(-COEF_MAX);
    end
    return v[31:0];
  endfunction

  // zero, or magnitude below the epsilon
  function automatic logic is_tiny(input logic signed [32:0] v, input logic [15:0] nz);
    logic [32:0] mag;
    mag = v[32] ? 33'(-v) : 33'(v);
    return (v == 33'sd0) || (mag < {17'd0, nz});
  endfunction

  assign busy    = (state_r != F_IDLE);
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign q_data  = ray_r;
  assign fl_prod = {{2{prod_r[63]}}, prod_r[63:16]};
  assign disc_nxt = bb_r - (prod_r <<< 2);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == F_MAC) begin
      case (step_r)
        4'd0:    begin mul_a = ray_r.dx; mul_b = ray_r.dx; end
        4'd1:    begin mul_a = ray_r.dy; mul_b = ray_r.dy; end
        4'd2:    begin mul_a = ray_r.dz; mul_b = ray_r.dz; end
        4'd3:    begin mul_a = ray_r.ox; mul_b = ray_r.dx; end
        4'd4:    begin mul_a = ray_r.oy; mul_b = ray_r.dy; end
        4'd5:    begin mul_a = ray_r.oz; mul_b = ray_r.dz; end
        4'd6:    begin mul_a = ray_r.ox; mul_b = ray_r.ox; end
        4'd7:    begin mul_a = ray_r.oy; mul_b = ray_r.oy; end
        4'd8:    begin mul_a = ray_r.oz; mul_b = ray_r.oz; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == F_DISC) begin
      case (step_r)
        4'd0:    begin mul_a = ray_r.b; mul_b = ray_r.b; end
        4'd1:    begin mul_a = ray_r.a; mul_b = ray_r.c; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // sequencer: one product per cycle, registered and accumulated in the following cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (start) begin
            ray_r.ox <= in_origin_x;
            ray_r.oy <= in_origin_y;
            ray_r.oz <= in_origin_z;
            ray_r.dx <= in_dir_x;
            ray_r.dy <= in_dir_y;
            ray_r.dz <= in_dir_z;
            step_r   <= '0;
            state_r  <= F_MAC;
          end
        end
        F_MAC: begin
          case (step_r)
            4'd0: begin a_acc_r <= '0; b_acc_r <= '0; c_acc_r <= '0; end
            4'd1: a_acc_r <= a_acc_r + fl_prod;
            4'd2: a_acc_r <= a_acc_r - fl_prod;
            4'd3: a_acc_r <= a_acc_r + fl_prod;
            4'd4: b_acc_r <= b_acc_r + fl_prod;
            4'd5: b_acc_r <= b_acc_r - fl_prod;
            4'd6: b_acc_r <= b_acc_r + fl_prod;
            4'd7: c_acc_r <= c_acc_r + fl_prod;
            4'd8: c_acc_r <= c_acc_r - fl_prod;
            4'd9: c_acc_r <= c_acc_r + fl_prod;
            default: ;
          endcase
          if (step_r == 4'd9) begin
            state_r <= F_CLAMP;
          end
          step_r <= step_r + 4'd1;
        end
        F_CLAMP: begin
          ray_r.a <= clamp_coef({a_acc_r[49], a_acc_r});
          ray_r.b <= clamp_coef({b_acc_r, 1'b0});
          ray_r.c <= clamp_coef({c_acc_r[49], c_acc_r});
          step_r  <= '0;
          state_r <= F_DISC;
        end
        F_DISC: begin
          if (step_r == 4'd1) begin
            bb_r <= prod_r;
          end
          if (step_r == 4'd2) begin
            ray_r.disc         <= disc_nxt;
            ray_r.cls.a_tiny   <= is_tiny({ray_r.a[31], ray_r.a}, cfg.near_zero);
            ray_r.cls.b_tiny   <= is_tiny({ray_r.b[31], ray_r.b}, cfg.near_zero);
            ray_r.cls.dy_tiny  <= is_tiny({ray_r.dy[31], ray_r.dy}, cfg.near_zero);
            ray_r.cls.disc_neg <= disc_nxt[63];
            state_r            <= F_PUSH;
          end
          step_r <= step_r + 4'd1;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/rci_fifo.sv
// Short queue of classified rays between front end and back end.
module rci_fifo import rci_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rci_ray_t din,
  output logic     full,
  input  logic     pop,
  output rci_ray_t dout,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rci_ray_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/rci_div.sv
// Radix-2 restoring divider: saturated (num * 65536) / den, truncated toward zero.
module rci_div import rci_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [DIV_NUM_W-1:0] num,
  input  logic signed [DIV_DEN_W-1:0] den,
  output logic                        done,
  output logic signed [31:0]          quo
);

  localparam int DVD_W = DIV_NUM_W + 16;
  localparam int DSR_W = DIV_DEN_W - 1;
  localparam int CNT_W = $clog2(DVD_W);

  logic                 run_r, neg_r, done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DVD_W-1:0]     dvd_r;
  logic [DSR_W-1:0]     dsr_r, rem_r;
  logic signed [31:0]   quo_r;
  logic [DIV_NUM_W-1:0] num_mag;
  logic [DIV_DEN_W-1:0] den_mag;
  logic [DSR_W:0]       trial;
  logic                 q_bit;
  logic [DSR_W:0]       diff;
  logic [DVD_W-1:0]     q_full;

  assign num_mag = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
  assign den_mag = den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);
  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign q_bit   = (trial >= {1'b0, dsr_r});
  assign diff    = trial - {1'b0, dsr_r};
  assign q_full  = {dvd_r[DVD_W-2:0], q_bit};
  assign done    = done_r;
  assign quo     = quo_r;

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        neg_r <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
        dvd_r <= {num_mag, 16'd0};
        dsr_r <= den_mag[DSR_W-1:0];
        rem_r <= '0;
      end else if (run_r) begin
        rem_r <= q_bit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        dvd_r <= q_full;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          if (!neg_r) begin
            quo_r <= (q_full > DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q_full[31:0];
          end else begin
            quo_r <= (q_full > DVD_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                        : 32'(~q_full[31:0] + 32'd1);
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/rci_back.sv
// Back end: roots, side and cap tests, result ordering and delivery.
module rci_back import rci_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rci_cfg_t           cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  rci_ray_t           q_data,
  output logic               out_strobe,
  output logic signed [31:0] out_hit_t,
  output logic        [1:0]  out_hit_kind,
  output logic               out_hit_valid,
  output logic               out_last
);

  typedef enum logic [4:0] {
    B_IDLE, B_CLASS, B_SQRT, B_SQRT_END, B_DIV_LO, B_DIV_HI, B_DIV_ONE,
    B_SIDE_MUL, B_SIDE_CHK, B_CAPS, B_CAP_DIV, B_CAP_MX, B_CAP_MZ, B_CAP_ZR,
    B_CAP_SQX, B_CAP_SQZ, B_CAP_RR, B_CAP_CMP, B_CAP_NEXT, B_FIN
  } state_t;

  state_t                      state_r;
  rci_ray_t                    ray_r;
  logic [63:0]                 v_r, res_r, bit_r, sq_r;
  logic [4:0]                  sq_cnt_r;
  logic signed [31:0]          t1_r, cur_t_r, t0_r;
  logic [1:0]                  cur_kind_r;
  logic                        second_r, cap_sel_r;
  logic signed [49:0]          x_r, z_r;
  logic signed [65:0]          prod_r;
  logic                        pend_v_r;
  logic signed [31:0]          pend_t_r;
  logic [1:0]                  pend_kind_r;
  logic                        out_strobe_r, out_hit_valid_r, out_last_r;
  logic signed [31:0]          out_hit_t_r;
  logic [1:0]                  out_hit_kind_r;
  logic                        div_go_r;
  logic signed [DIV_NUM_W-1:0] div_num_r;
  logic signed [DIV_DEN_W-1:0] div_den_r;
  logic                        div_done;
  logic signed [31:0]          div_quo;

  logic signed [32:0]          mul_a, mul_b;
  logic signed [49:0]          fl_prod, y_hit, lo_lim, hi_lim;
  logic                        in_bounds;
  logic signed [15:0]          cap_bound;
  logic signed [16:0]          bnd17;
  logic [16:0]                 abs_b;
  logic [32:0]                 r_val;
  logic [49:0]                 ax, az;
  logic                        range_ok;
  logic [63:0]                 sqrt_trial;
  logic                        hit_now;
  logic [1:0]                  hit_kind_now;
  logic [32:0]                 s_val;

  rci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign q_pop         = (state_r == B_IDLE) && !q_empty;
  assign out_strobe    = out_strobe_r;
  assign out_hit_t     = out_hit_t_r;
  assign out_hit_kind  = out_hit_kind_r;
  assign out_hit_valid = out_hit_valid_r;
  assign out_last      = out_last_r;

  // y of a side hit against the bounds
  assign fl_prod   = {{2{prod_r[63]}}, prod_r[63:16]};
  assign y_hit     = {{18{ray_r.oy[31]}}, ray_r.oy} + fl_prod;
  assign lo_lim    = {{18{cfg.y_lower[15]}}, cfg.y_lower, 16'd0};
  assign hi_lim    = {{18{cfg.y_upper[15]}}, cfg.y_upper, 16'd0};
  assign in_bounds = (lo_lim < y_hit) && (y_hit < hi_lim);

  // cap disc radius and coarse range test
  assign cap_bound = cap_sel_r ? cfg.y_upper : cfg.y_lower;
  assign bnd17     = {cap_bound[15], cap_bound};
  assign abs_b     = bnd17[16] ? 17'(-bnd17) : 17'(bnd17);
  assign r_val     = {abs_b, 16'd0};
  assign ax        = x_r[49] ? 50'(-x_r) : 50'(x_r);
  assign az        = z_r[49] ? 50'(-z_r) : 50'(z_r);
  assign range_ok  = (ax <= {17'd0, r_val}) && (az <= {17'd0, r_val});

  assign sqrt_trial = res_r + bit_r;
  assign s_val      = res_r[32:0];

  assign hit_now = ((state_r == B_SIDE_CHK) && in_bounds) ||
                   ((state_r == B_CAP_CMP) && (sq_r <= prod_r[63:0]));
  assign hit_kind_now = (state_r == B_SIDE_CHK) ? cur_kind_r :
                        (cap_sel_r ? KIND_UPPER_CAP : KIND_LOWER_CAP);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      B_SIDE_MUL: begin mul_a = {cur_t_r[31], cur_t_r}; mul_b = {ray_r.dy[31], ray_r.dy}; end
      B_CAP_MX:   begin mul_a = {cur_t_r[31], cur_t_r}; mul_b = {ray_r.dx[31], ray_r.dx}; end
      B_CAP_MZ:   begin mul_a = {cur_t_r[31], cur_t_r}; mul_b = {ray_r.dz[31], ray_r.dz}; end
      B_CAP_SQX:  begin mul_a = ax[32:0]; mul_b = ax[32:0]; end
      B_CAP_SQZ:  begin mul_a = az[32:0]; mul_b = az[32:0]; end
      B_CAP_RR:   begin mul_a = r_val;    mul_b = r_val;    end
      default:    begin mul_a = '0;       mul_b = '0;       end
    endcase
  end

  // sequencer, result holding and delivery
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r      <= B_IDLE;
      out_strobe_r <= 1'b0;
      pend_v_r     <= 1'b0;
      div_go_r     <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      div_go_r     <= 1'b0;

      // a new hit pushes the held one out, which is then known not to be last
      if (hit_now) begin
        if (pend_v_r) begin
          out_strobe_r    <= 1'b1;
          out_hit_t_r     <= pend_t_r;
          out_hit_kind_r  <= pend_kind_r;
          out_hit_valid_r <= 1'b1;
          out_last_r      <= 1'b0;
        end
        pend_v_r    <= 1'b1;
        pend_t_r    <= cur_t_r;
        pend_kind_r <= hit_kind_now;
      end

      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            ray_r   <= q_data;
            state_r <= B_CLASS;
          end
        end
        B_CLASS: begin
          if (ray_r.cls.a_tiny) begin
            if (!ray_r.cls.b_tiny) begin
              div_go_r  <= 1'b1;
              div_num_r <= -{{4{ray_r.c[31]}}, ray_r.c};
              div_den_r <= {ray_r.b[31], ray_r.b, 1'b0};
              state_r   <= B_DIV_ONE;
            end else begin
              state_r <= B_CAPS;
            end
          end else if (ray_r.cls.disc_neg) begin
            state_r <= B_FIN;
          end else begin
            v_r      <= ray_r.disc;
            res_r    <= '0;
            bit_r    <= 64'h4000_0000_0000_0000;
            sq_cnt_r <= '0;
            state_r  <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (v_r >= sqrt_trial) begin
            v_r   <= v_r - sqrt_trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r    <= bit_r >> 2;
          sq_cnt_r <= sq_cnt_r + 5'd1;
          if (sq_cnt_r == 5'd31) begin
            state_r <= B_SQRT_END;
          end
        end
        B_SQRT_END: begin
          div_go_r  <= 1'b1;
          div_num_r <= -{{4{ray_r.b[31]}}, ray_r.b} - {3'd0, s_val};
          div_den_r <= {ray_r.a[31], ray_r.a, 1'b0};
          state_r   <= B_DIV_LO;
        end
        B_DIV_LO: begin
          if (div_done) begin
            t0_r      <= div_quo;
            div_go_r  <= 1'b1;
            div_num_r <= -{{4{ray_r.b[31]}}, ray_r.b} + {3'd0, s_val};
            state_r   <= B_DIV_HI;
          end
        end
        B_DIV_HI: begin
          if (div_done) begin
            if (t0_r > div_quo) begin
              cur_t_r <= div_quo;
              t1_r    <= t0_r;
            end else begin
              cur_t_r <= t0_r;
              t1_r    <= div_quo;
            end
            cur_kind_r <= KIND_SIDE_NEAR;
            second_r   <= 1'b1;
            state_r    <= B_SIDE_MUL;
          end
        end
        B_DIV_ONE: begin
          if (div_done) begin
            cur_t_r    <= div_quo;
            cur_kind_r <= KIND_SIDE_NEAR;
            second_r   <= 1'b0;
            state_r    <= B_SIDE_MUL;
          end
        end
        B_SIDE_MUL: state_r <= B_SIDE_CHK;
        B_SIDE_CHK: begin
          if (second_r) begin
            cur_t_r    <= t1_r;
            cur_kind_r <= KIND_SIDE_FAR;
            second_r   <= 1'b0;
            state_r    <= B_SIDE_MUL;
          end else begin
            state_r <= B_CAPS;
          end
        end
        B_CAPS: begin
          if (cfg.caps_closed && !ray_r.cls.dy_tiny) begin
            cap_sel_r <= 1'b0;
            div_go_r  <= 1'b1;
            div_num_r <= {{4{cfg.y_lower[15]}}, cfg.y_lower, 16'd0} -
                         {{4{ray_r.oy[31]}}, ray_r.oy};
            div_den_r <= {{2{ray_r.dy[31]}}, ray_r.dy};
            state_r   <= B_CAP_DIV;
          end else begin
            state_r <= B_FIN;
          end
        end
        B_CAP_DIV: begin
          if (div_done) begin
            cur_t_r <= div_quo;
            state_r <= B_CAP_MX;
          end
        end
        B_CAP_MX: state_r <= B_CAP_MZ;
        B_CAP_MZ: begin
          x_r     <= {{18{ray_r.ox[31]}}, ray_r.ox} + fl_prod;
          state_r <= B_CAP_ZR;
        end
        B_CAP_ZR: begin
          z_r     <= {{18{ray_r.oz[31]}}, ray_r.oz} + fl_prod;
          state_r <= B_CAP_SQX;
        end
        B_CAP_SQX: state_r <= range_ok ? B_CAP_SQZ : B_CAP_NEXT;
        B_CAP_SQZ: begin
          sq_r    <= prod_r[63:0];
          state_r <= B_CAP_RR;
        end
        B_CAP_RR: begin
          sq_r    <= sq_r + prod_r[63:0];
          state_r <= B_CAP_CMP;
        end
        B_CAP_CMP: state_r <= B_CAP_NEXT;
        B_CAP_NEXT: begin
          if (!cap_sel_r) begin
            cap_sel_r <= 1'b1;
            div_go_r  <= 1'b1;
            div_num_r <= {{4{cfg.y_upper[15]}}, cfg.y_upper, 16'd0} -
                         {{4{ray_r.oy[31]}}, ray_r.oy};
            div_den_r <= {{2{ray_r.dy[31]}}, ray_r.dy};
            state_r   <= B_CAP_DIV;
          end else begin
            state_r <= B_FIN;
          end
        end
        B_FIN: begin
          out_strobe_r <= 1'b1;
          out_last_r   <= 1'b1;
          if (pend_v_r) begin
            out_hit_t_r     <= pend_t_r;
            out_hit_kind_r  <= pend_kind_r;
            out_hit_valid_r <= 1'b1;
          end else begin
            out_hit_t_r     <= '0;
            out_hit_kind_r  <= KIND_SIDE_NEAR;
            out_hit_valid_r <= 1'b0;
          end
          pend_v_r <= 1'b0;
          state_r  <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/ray_cone_intersect.sv
// Top level of the ray / truncated double cone intersection block.
//
//  channel  | transfer when          | contents
//  ---------+------------------------+----------------------------------------------
//  in_      | start & !busy          | in_origin_x/y/z, in_dir_x/y/z (Q16.16)
//  out_     | out_strobe (one cycle) | out_hit_t, out_hit_kind, out_hit_valid, out_last
//  cfg_     | cfg_valid & cfg_ready  | cfg_index, cfg_data (cfg_ready is always high)
//
// The front end forms coefficients and discriminant of each ray (one shared
// 32x32 multiplier), then hands the ray to a queue of QUEUE_DEPTH entries.
// The back end's time per ray is set by a 32-step square root and up to four
// passes of its shared radix-2 divider.
// Synchronous reset clears control state and the configuration registers.
// Results cannot be held off by the receiver; busy holds the sender off.
module ray_cone_intersect import rci_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  output logic               out_strobe,
  output logic signed [31:0] out_hit_t,
  output logic        [1:0]  out_hit_kind,
  output logic               out_hit_valid,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [15:0] cfg_data
);

  rci_cfg_t cfg_r;
  logic     q_full, q_push, q_empty, q_pop;
  rci_ray_t q_in, q_out;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.y_lower     <= Y_LOWER_RST;
      cfg_r.y_upper     <= Y_UPPER_RST;
      cfg_r.caps_closed <= CAPS_RST;
      cfg_r.near_zero   <= NEAR_ZERO_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_Y_LOWER:     cfg_r.y_lower     <= cfg_data;
        CFG_Y_UPPER:     cfg_r.y_upper     <= cfg_data;
        CFG_CAPS_CLOSED: cfg_r.caps_closed <= cfg_data[0];
        CFG_NEAR_ZERO:   cfg_r.near_zero   <= cfg_data;
        default: ;
      endcase
    end
  end

  rci_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_origin_x (in_origin_x),
    .in_origin_y (in_origin_y),
    .in_origin_z (in_origin_z),
    .in_dir_x    (in_dir_x),
    .in_dir_y    (in_dir_y),
    .in_dir_z    (in_dir_z),
    .cfg         (cfg_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  rci_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  rci_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_out),
    .out_strobe    (out_strobe),
    .out_hit_t     (out_hit_t),
    .out_hit_kind  (out_hit_kind),
    .out_hit_valid (out_hit_valid),
    .out_last      (out_last)
  );

endmodule

// File: hw/rtl/rci_checker.sv
// Port-level checks of the intersection block, bound to the top level.
module rci_checker import rci_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic signed [31:0] out_hit_t,
  input logic        [1:0]  out_hit_kind,
  input logic               out_hit_valid,
  input logic               out_last
);

  // a miss is a single, zeroed, final result
  a_miss_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_hit_valid |-> out_last && out_hit_kind == KIND_SIDE_NEAR &&
                                     out_hit_t == 32'sd0)
    else $error("miss result not zeroed or not last");

  // an upper cap hit always closes the ray
  a_upper_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_hit_valid && out_hit_kind == KIND_UPPER_CAP |-> out_last)
    else $error("upper cap hit not last");

  // a taken ray keeps the front end occupied
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after transfer");

  // reset quiets both sides
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe && !busy)
    else $error("activity right after reset");

endmodule

bind ray_cone_intersect rci_checker u_rci_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_hit_t     (out_hit_t),
  .out_hit_kind  (out_hit_kind),
  .out_hit_valid (out_hit_valid),
  .out_last      (out_last)
);

// File: test/ray_cone_intersect_tb.sv
// Self-checking testbench for the ray / truncated double cone intersection block.
`timescale 1ns / 1ps

module ray_cone_intersect_tb import rci_pkg::*; ();

  localparam int  CYCLE_LIMIT = 800000;
  localparam int  DRAIN_WAIT  = 400;
  localparam longint COEF_MAX = 64'sd1073741823;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic signed [31:0] t;
    logic [1:0]         kind;
    logic               valid;
    logic               last;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_strobe;
  logic signed [31:0] out_hit_t;
  logic [1:0] out_hit_kind;
  logic out_hit_valid, out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow of the configuration registers
  logic signed [15:0] y_lo = Y_LOWER_RST;
  logic signed [15:0] y_hi = Y_UPPER_RST;
  logic               caps_on = CAPS_RST;
  logic [15:0]        eps = NEAR_ZERO_RST;

  ray_t pending_rays[$];
  hit_t hits_due[$];
  int   errors = 0;
  int   cycles = 0;
  int   send_idle_pct = 24;

  ray_cone_intersect u_top (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Fixed-point helpers
  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clamp_coef(longint v);
    if (v > COEF_MAX) return COEF_MAX;
    if (v < -COEF_MAX) return -COEF_MAX;
    return v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit is_tiny(longint v);
    return v == 0 || absl(v) < longint'(eps);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    return sat32((num * 65536) / den);
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit y_inside(longint t, longint oy, longint dy);
    longint y;
    y = oy + fl16(t * dy);
    return (longint'(y_lo) * 65536 < y) && (y < longint'(y_hi) * 65536);
  endfunction

  function automatic bit on_disc(longint t, longint bound, longint ox, longint oz,
                                 longint dx, longint dz);
    longint x, z;
    longint unsigned r, ax, az;
    x = ox + fl16(t * dx);
    z = oz + fl16(t * dz);
    r = absl(bound) * 65536;
    ax = absl(x);
    az = absl(z);
    if (ax > r || az > r) return 1'b0;
    return ax * ax + az * az <= r * r;
  endfunction

  // Append one ray to the send queue
  task automatic add_ray(ray_t r);
    pending_rays.insert(pending_rays.size(), r);
  endtask

  // Work out the hits of one ray and queue them
  task automatic predict_hits(ray_t r);
    longint ox, oy, oz, dx, dy, dz, a, b, c, t, t0, t1, s, disc;
    hit_t found[4];
    int n;
    bit caps_ok;
    ox = r.ox; oy = r.oy; oz = r.oz; dx = r.dx; dy = r.dy; dz = r.dz;
    n = 0;
    caps_ok = 1'b1;
    a = clamp_coef(fl16(dx * dx) - fl16(dy * dy) + fl16(dz * dz));
    b = clamp_coef(2 * (fl16(ox * dx) - fl16(oy * dy) + fl16(oz * dz)));
    c = clamp_coef(fl16(ox * ox) - fl16(oy * oy) + fl16(oz * oz));
    if (is_tiny(a)) begin
      // single root when the quadratic degenerates
      if (!is_tiny(b)) begin
        t = fx_div(-c, 2 * b);
        if (y_inside(t, oy, dy)) found[n++] = '{32'(t), KIND_SIDE_NEAR, 1'b1, 1'b0};
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        caps_ok = 1'b0;
      end else begin
        s = longint'(sqrt_floor(disc));
        t0 = fx_div(-b - s, 2 * a);
        t1 = fx_div(-b + s, 2 * a);
        if (t0 > t1) begin
          t = t0; t0 = t1; t1 = t;
        end
        if (y_inside(t0, oy, dy)) found[n++] = '{32'(t0), KIND_SIDE_NEAR, 1'b1, 1'b0};
        if (y_inside(t1, oy, dy)) found[n++] = '{32'(t1), KIND_SIDE_FAR, 1'b1, 1'b0};
      end
    end
    // cap discs, skipped when caps are open, on a negative discriminant, or for rays flat in y
    if (caps_ok && caps_on && !is_tiny(dy)) begin
      t = fx_div(longint'(y_lo) * 65536 - oy, dy);
      if (on_disc(t, y_lo, ox, oz, dx, dz))
        found[n++] = '{32'(t), KIND_LOWER_CAP, 1'b1, 1'b0};
      t = fx_div(longint'(y_hi) * 65536 - oy, dy);
      if (on_disc(t, y_hi, ox, oz, dx, dz))
        found[n++] = '{32'(t), KIND_UPPER_CAP, 1'b1, 1'b0};
    end
    if (n == 0) found[n++] = '{32'sd0, KIND_SIDE_NEAR, 1'b0, 1'b0};
    found[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) hits_due.insert(hits_due.size(), found[i]);
  endtask

  // Driver: predict on each accepted ray, then present the next one
  always @(posedge clk) begin
    ray_t nxt;
    if (rst_n) begin
      if (start && !busy) predict_hits('{in_origin_x, in_origin_y, in_origin_z,
                                         in_dir_x, in_dir_y, in_dir_z});
      if (!start || !busy) begin
        if (pending_rays.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_rays.pop_front();
          start <= 1'b1;
          in_origin_x <= nxt.ox; in_origin_y <= nxt.oy; in_origin_z <= nxt.oz;
          in_dir_x <= nxt.dx; in_dir_y <= nxt.dy; in_dir_z <= nxt.dz;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result transfer against the oldest expectation
  always @(posedge clk) begin
    hit_t exp_hit;
    if (rst_n && out_strobe) begin
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result t=%0d kind=%0d valid=%0b last=%0b", $time,
                 out_hit_t, out_hit_kind, out_hit_valid, out_last);
        errors++;
      end else begin
        exp_hit = hits_due.pop_front();
        if (out_hit_t !== exp_hit.t) begin
          $display("%0t: hit_t expected %0d actual %0d", $time, exp_hit.t, out_hit_t);
          errors++;
        end
        if (out_hit_kind !== exp_hit.kind) begin
          $display("%0t: hit_kind expected %0d actual %0d", $time, exp_hit.kind,
                   out_hit_kind);
          errors++;
        end
        if (out_hit_valid !== exp_hit.valid) begin
          $display("%0t: hit_valid expected %0b actual %0b", $time, exp_hit.valid,
                   out_hit_valid);
          errors++;
        end
        if (out_last !== exp_hit.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_hit.last, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_Y_LOWER:     y_lo = data;
      CFG_Y_UPPER:     y_hi = data;
      CFG_CAPS_CLOSED: caps_on = data[0];
      CFG_NEAR_ZERO:   eps = data;
      default: ;
    endcase
  endtask

  task automatic set_bounds(int lo, int hi, bit caps, int near);
    write_reg(CFG_Y_LOWER, 16'(lo));
    write_reg(CFG_Y_UPPER, 16'(hi));
    write_reg(CFG_CAPS_CLOSED, {15'd0, caps});
    write_reg(CFG_NEAR_ZERO, 16'(near));
  endtask

  // Wait for every queued ray to go out and every hit to come back
  task automatic drain();
    do @(posedge clk); while (pending_rays.size() != 0 || start || hits_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Mostly small coordinates so rays meet the cone, some full range
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 512))) - 256;
      default: return $signed(32'($urandom_range(0, 20 << 16))) - (10 << 16);
    endcase
  endfunction

  task automatic queue_random(int count);
    ray_t r;
    for (int i = 0; i < count; i++) begin
      r = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord()};
      case ($urandom_range(0, 7))
        0: begin  // direction on the cone surface: a vanishes
          r.dz = 0;
          r.dy = ($urandom_range(0, 1)) ? r.dx : -r.dx;
        end
        1: r.dy = $signed(32'($urandom_range(0, 15))) - 7;  // nearly flat in y
        default: ;
      endcase
      add_ray(r);
    end
  endtask

  localparam logic signed [31:0] ONE  = 32'sd65536;
  localparam logic signed [31:0] SMAX = 32'h7fffffff;
  localparam logic signed [31:0] SMIN = 32'h80000000;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rays under reset settings, then with closed caps
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) set_bounds(-4, 4, 1'b1, 7);
      add_ray('{0, 0, 0, 0, 0, 0});
      add_ray('{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX});
      add_ray('{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN});
      add_ray('{SMAX, SMIN, SMAX, SMIN, SMAX, SMIN});
      add_ray('{-1, -1, -1, -1, -1, -1});
      // straight down the axis, crosses both caps
      add_ray('{0, 8 * ONE, 0, 0, -ONE, 0});
      // sideways through one nappe, entering and leaving it
      add_ray('{-8 * ONE, ONE / 2, 0, ONE, 0, 0});
      // direction on the surface: single root
      add_ray('{ONE, 0, 0, ONE, ONE, 0});
      // horizontal at y = 2: positive discriminant, meets the cone twice
      add_ray('{0, 2 * ONE, 0, 0, 0, ONE});
      // flat in y but below epsilon, off axis
      add_ray('{0, -ONE / 2, 3 * ONE, ONE, 3, 0});
      add_ray('{ONE / 4, -6 * ONE, 0, 0, ONE, ONE / 8});
      drain();
    end

    // Random phases across settings: sender idling 24%, 80%, none
    send_idle_pct = 24;
    queue_random(130);
    drain();
    set_bounds(-32768, 32767, 1'b0, 65535);
    send_idle_pct = 80;
    queue_random(60);
    drain();
    set_bounds(5, -5, 1'b1, 0);
    queue_random(60);
    drain();
    set_bounds(-6, 3, 1'b1, 0);
    send_idle_pct = 0;
    queue_random(130);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
